// ===== hdl/pkhr_pkg.sv =====
// ----------------------------------------------------------------------------
// Peer key hash registry package
// Shared types, codes and constants for the registry block.
// ----------------------------------------------------------------------------
package pkhr_pkg;

  localparam int TABLE_SLOTS_DEF = 256;
  localparam int FD_LIMIT_DEF    = 1024;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  typedef enum logic [1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_SETPREF = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_FOUND     = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_INSERTED  = 3'd2,
    STS_RECONN    = 3'd3,
    STS_REMOVED   = 3'd4,
    STS_FULL      = 3'd5,
    STS_UNMAPPED  = 3'd6,
    STS_PREF_SET  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  typedef struct packed {
    slot_state_t        state;
    logic [255:0]       key;
    logic signed [15:0] handle;
    logic [7:0]         pref;
  } slot_rec_t;

  typedef struct packed {
    action_t            action;
    logic [255:0]       key;
    logic signed [15:0] handle;
    logic [7:0]         preferred_value;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         slot;
    logic signed [15:0] peer_handle;
    logic [7:0]         peer_preferred;
    logic [8:0]         live_count;
  } rsp_item_t;

endpackage

// ===== hdl/pkhr_if.sv =====
// ----------------------------------------------------------------------------
// Peer key hash registry channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pkhr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [63:0]        key_word0;
  logic [63:0]        key_word1;
  logic [63:0]        key_word2;
  logic [63:0]        key_word3;
  logic signed [15:0] handle;
  logic [7:0]         preferred_value;

  modport source (output valid, action, key_word0, key_word1, key_word2, key_word3,
                  handle, preferred_value, input ready);
  modport sink (input valid, action, key_word0, key_word1, key_word2, key_word3,
                handle, preferred_value, output ready);
endinterface

interface pkhr_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         slot;
  logic signed [15:0] peer_handle;
  logic [7:0]         peer_preferred;
  logic [8:0]         live_count;

  modport source (output valid, status, slot, peer_handle, peer_preferred, live_count,
                  input ready);
  modport sink (input valid, status, slot, peer_handle, peer_preferred, live_count,
                output ready);
endinterface

// ===== hdl/pkhr_hash.sv =====
// ----------------------------------------------------------------------------
// FNV-1a key hash
// Hashes the 32 key bytes, one byte and one multiply per cycle.
// ----------------------------------------------------------------------------
module pkhr_hash (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  output logic         done,
  output logic [31:0]  hash
);
  import pkhr_pkg::*;

  logic         busy;
  logic [4:0]   cnt;
  logic [255:0] key_sr;
  logic [31:0]  mix;

  assign mix = hash ^ {24'd0, key_sr[255:248]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        key_sr <= key;
        hash   <= FNV_OFFSET;
      end else if (busy) begin
        hash   <= 32'(mix * FNV_PRIME);
        key_sr <= {key_sr[247:0], 8'd0};
        cnt    <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/pkhr_engine.sv =====
// ----------------------------------------------------------------------------
// Registry engine
// Slot store and handle map memories with the probe sequencer.
// ----------------------------------------------------------------------------
module pkhr_engine #(
  parameter int TABLE_SLOTS = pkhr_pkg::TABLE_SLOTS_DEF,
  parameter int FD_LIMIT    = pkhr_pkg::FD_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  output logic                ready,
  input  logic                start,
  input  pkhr_pkg::req_item_t start_item,
  output logic                res_valid,
  input  logic                res_take,
  output pkhr_pkg::rsp_item_t res
);
  import pkhr_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int MAP_W  = (FD_LIMIT > 1) ? $clog2(FD_LIMIT) : 1;
  localparam int LC_W   = $clog2(TABLE_SLOTS + 1);
  localparam int CLR_N  = (TABLE_SLOTS > FD_LIMIT) ? TABLE_SLOTS : FD_LIMIT;
  localparam int CLR_W  = $clog2(CLR_N + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_EV, S_MAP_RD, S_MAP_EV,
    S_PREF_EV, S_UNMAP, S_MAP_SET, S_DONE
  } state_t;

  state_t             state;
  logic [CLR_W-1:0]   clr_cnt;
  req_item_t          item;
  logic [SLOT_W-1:0]  probe;
  logic [SLOT_W-1:0]  steps;
  logic [LC_W-1:0]    live;
  logic signed [15:0] old_handle;
  logic               do_map;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic signed [15:0] res_handle;
  logic [7:0]         res_pref;

  // Slot store: one record per slot, read data registered.
  slot_rec_t          slot_mem [TABLE_SLOTS];
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr;
  slot_rec_t          slot_wdata;
  logic               slot_re;
  logic [SLOT_W-1:0]  slot_raddr;
  slot_rec_t          slot_q;

  // Handle map: valid bit over slot index.
  logic [SLOT_W:0]    map_mem [FD_LIMIT];
  logic               map_we;
  logic [MAP_W-1:0]   map_waddr;
  logic [SLOT_W:0]    map_wdata;
  logic               map_re;
  logic [SLOT_W:0]    map_q;

  logic               hash_start;
  logic               hash_done;
  logic [31:0]        hash_val;
  logic               q_live;
  logic               q_match;
  logic               is_insert;

  function automatic logic handle_ok(logic signed [15:0] h);
    return !h[15] && (16'(unsigned'(h)) < 16'(FD_LIMIT));
  endfunction

  pkhr_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (start_item.key),
    .done  (hash_done),
    .hash  (hash_val)
  );

  assign hash_start = (state == S_IDLE) && start && (start_item.action != ACT_SETPREF);
  assign ready      = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign q_live     = (slot_q.state == SLOT_LIVE);
  assign q_match    = q_live && (slot_q.key == item.key);
  assign is_insert  = (item.action == ACT_INSERT);

  assign res.status         = res_status;
  assign res.slot           = 8'(res_slot);
  assign res.peer_handle    = res_handle;
  assign res.peer_preferred = res_pref;
  assign res.live_count     = 9'(live);

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_q <= slot_mem[slot_raddr];
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_q <= map_mem[item.handle[MAP_W-1:0]];
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = probe;
    slot_wdata = slot_q;
    slot_re    = 1'b0;
    slot_raddr = probe;
    map_we     = 1'b0;
    map_waddr  = item.handle[MAP_W-1:0];
    map_wdata  = '0;
    map_re     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        slot_we    = (clr_cnt < CLR_W'(TABLE_SLOTS));
        slot_waddr = clr_cnt[SLOT_W-1:0];
        slot_wdata = '0;
        map_we     = (clr_cnt < CLR_W'(FD_LIMIT));
        map_waddr  = clr_cnt[MAP_W-1:0];
      end
      S_PROBE_RD: slot_re = 1'b1;
      S_PROBE_EV: begin
        if (q_match && is_insert) begin
          slot_we           = 1'b1;
          slot_wdata.handle = item.handle;
        end else if (q_match && item.action == ACT_REMOVE) begin
          slot_we           = 1'b1;
          slot_wdata.state  = SLOT_TOMB;
          slot_wdata.handle = -16'sd1;
        end else if (!q_match && is_insert && !q_live) begin
          slot_we           = 1'b1;
          slot_wdata.state  = SLOT_LIVE;
          slot_wdata.key    = item.key;
          slot_wdata.handle = item.handle;
          slot_wdata.pref   = 8'd0;
        end
      end
      S_MAP_RD: map_re = 1'b1;
      S_MAP_EV: begin
        slot_re    = map_q[SLOT_W];
        slot_raddr = map_q[SLOT_W-1:0];
      end
      S_PREF_EV: begin
        slot_we         = 1'b1;
        slot_wdata.pref = item.preferred_value;
      end
      S_UNMAP: begin
        map_we    = 1'b1;
        map_waddr = old_handle[MAP_W-1:0];
      end
      S_MAP_SET: begin
        map_we    = 1'b1;
        map_wdata = {1'b1, probe};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      live    <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (clr_cnt == CLR_W'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            item <= start_item;
            if (start_item.action != ACT_SETPREF) begin
              state <= S_HASH;
            end else if (handle_ok(start_item.handle)) begin
              state <= S_MAP_RD;
            end else begin
              res_status <= STS_UNMAPPED;
              res_slot   <= '0;
              res_handle <= '0;
              res_pref   <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            probe <= hash_val[SLOT_W-1:0];
            steps <= '0;
            state <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: state <= S_PROBE_EV;
        S_PROBE_EV: begin
          res_slot <= probe;
          if (q_match) begin
            old_handle <= slot_q.handle;
            res_pref   <= slot_q.pref;
            unique case (item.action)
              ACT_INSERT: begin
                res_status <= STS_RECONN;
                res_handle <= item.handle;
                do_map     <= handle_ok(item.handle);
                if (handle_ok(slot_q.handle)) state <= S_UNMAP;
                else if (handle_ok(item.handle)) state <= S_MAP_SET;
                else state <= S_DONE;
              end
              ACT_REMOVE: begin
                res_status <= STS_REMOVED;
                res_handle <= -16'sd1;
                do_map     <= 1'b0;
                live       <= live - LC_W'(1);
                state      <= handle_ok(slot_q.handle) ? S_UNMAP : S_DONE;
              end
              default: begin
                res_status <= STS_FOUND;
                res_handle <= slot_q.handle;
                state      <= S_DONE;
              end
            endcase
          end else if (is_insert && !q_live) begin
            res_status <= STS_INSERTED;
            res_handle <= item.handle;
            res_pref   <= 8'd0;
            live       <= live + LC_W'(1);
            state      <= handle_ok(item.handle) ? S_MAP_SET : S_DONE;
          end else if ((!is_insert && slot_q.state == SLOT_EMPTY)
                       || steps == SLOT_W'(TABLE_SLOTS - 1)) begin
            res_status <= is_insert ? STS_FULL : STS_NOT_FOUND;
            res_slot   <= '0;
            res_handle <= '0;
            res_pref   <= '0;
            state      <= S_DONE;
          end else begin
            probe <= probe + SLOT_W'(1);
            steps <= steps + SLOT_W'(1);
            state <= S_PROBE_RD;
          end
        end
        S_MAP_RD: state <= S_MAP_EV;
        S_MAP_EV: begin
          if (map_q[SLOT_W]) begin
            probe <= map_q[SLOT_W-1:0];
            state <= S_PREF_EV;
          end else begin
            res_status <= STS_UNMAPPED;
            res_slot   <= '0;
            res_handle <= '0;
            res_pref   <= '0;
            state      <= S_DONE;
          end
        end
        S_PREF_EV: begin
          res_status <= STS_PREF_SET;
          res_slot   <= probe;
          res_handle <= slot_q.handle;
          res_pref   <= item.preferred_value;
          state      <= S_DONE;
        end
        S_UNMAP: state <= do_map ? S_MAP_SET : S_DONE;
        S_MAP_SET: state <= S_DONE;
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/peer_key_hash_registry_top.sv =====
// ----------------------------------------------------------------------------
// Peer key hash registry
// Open-addressing peer table keyed by 32-byte keys, FNV-1a hashed, with
// linear probing and a handle-to-slot map.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  req      in   action, key_word0..3, handle, preferred_value
//  rsp      out  status, slot, peer_handle, peer_preferred, live_count
//
// Set-preferred reads the handle map and the mapped slot, then writes the
// slot's preferred value. Lookup, insert and remove hash the key (one FNV
// multiply per byte), read and evaluate each probed slot on the slot memory
// port, and make up to 2 handle map writes; the response word is registered.
// After reset both memories are cleared, with req.ready low. A waiting
// response word does not stop the next request from being taken; only the
// finish of that request waits on rsp.
module peer_key_hash_registry_top #(
  parameter int TABLE_SLOTS = pkhr_pkg::TABLE_SLOTS_DEF,
  parameter int FD_LIMIT    = pkhr_pkg::FD_LIMIT_DEF
) (
  input logic        clk,
  input logic        rst,
  pkhr_req_if.sink   req,
  pkhr_rsp_if.source rsp
);
  import pkhr_pkg::*;

  req_item_t item;
  rsp_item_t res;
  logic      res_valid;
  logic      res_take;
  logic      eng_ready;

  assign item.action          = action_t'(req.action);
  assign item.key             = {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
  assign item.handle          = req.handle;
  assign item.preferred_value = req.preferred_value;
  assign req.ready            = eng_ready;
  assign res_take             = !rsp.valid || rsp.ready;

  pkhr_engine #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .FD_LIMIT    (FD_LIMIT)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .ready      (eng_ready),
    .start      (req.valid),
    .start_item (item),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      if (res_valid && res_take) begin
        rsp.valid          <= 1'b1;
        rsp.status         <= res.status;
        rsp.slot           <= res.slot;
        rsp.peer_handle    <= res.peer_handle;
        rsp.peer_preferred <= res.peer_preferred;
        rsp.live_count     <= res.live_count;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end
endmodule

// ===== bench/pkhr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer registry response checker
// Watches the request and response channels, keeps its own copy of the slot
// table and the handle map, predicts each response word and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module pkhr_checker #(
  parameter int TABLE_SLOTS = pkhr_pkg::TABLE_SLOTS_DEF,
  parameter int FD_LIMIT    = pkhr_pkg::FD_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst,
  pkhr_req_if  req,
  pkhr_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);
  import pkhr_pkg::*;

  slot_state_t        tbl_state [TABLE_SLOTS];
  logic [255:0]       tbl_key   [TABLE_SLOTS];
  logic signed [15:0] tbl_handle[TABLE_SLOTS];
  logic [7:0]         tbl_pref  [TABLE_SLOTS];
  bit                 map_ok    [FD_LIMIT];
  int                 map_slot  [FD_LIMIT];
  int                 live;
  rsp_item_t          expected_rsp[$];

  assign pending = expected_rsp.size();

  function automatic int key_home(logic [255:0] key);
    logic [31:0] h;
    h = FNV_OFFSET;
    for (int i = 0; i < 32; i++) begin
      h = (h ^ {24'd0, key[255 - 8 * i -: 8]}) * FNV_PRIME;
    end
    return int'(h & (TABLE_SLOTS - 1));
  endfunction

  function automatic bit mapped_range(logic signed [15:0] h);
    return (h >= 0) && (int'(h) < FD_LIMIT);
  endfunction

  function automatic rsp_item_t make_rsp(status_t st, int s, bit touched);
    rsp_item_t r;
    r = '0;
    r.status = st;
    if (touched) begin
      r.slot = s[7:0];
      r.peer_handle = tbl_handle[s];
      r.peer_preferred = tbl_pref[s];
    end
    r.live_count = live[8:0];
    return r;
  endfunction

  // Applies one request word to the table copy and returns the expected word.
  function automatic rsp_item_t registry_step(req_item_t it);
    int home;
    int s;
    if (it.action == ACT_SETPREF) begin
      if (mapped_range(it.handle) && map_ok[it.handle]) begin
        s = map_slot[it.handle];
        tbl_pref[s] = it.preferred_value;
        return make_rsp(STS_PREF_SET, s, 1);
      end
      return make_rsp(STS_UNMAPPED, 0, 0);
    end
    home = key_home(it.key);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      s = (home + i) & (TABLE_SLOTS - 1);
      if (tbl_state[s] == SLOT_LIVE && tbl_key[s] == it.key) begin
        if (it.action == ACT_LOOKUP) return make_rsp(STS_FOUND, s, 1);
        if (mapped_range(tbl_handle[s])) map_ok[tbl_handle[s]] = 0;
        if (it.action == ACT_INSERT) begin
          tbl_handle[s] = it.handle;
          if (mapped_range(it.handle)) begin
            map_ok[it.handle] = 1;
            map_slot[it.handle] = s;
          end
          return make_rsp(STS_RECONN, s, 1);
        end
        tbl_state[s] = SLOT_TOMB;
        tbl_handle[s] = -16'sd1;
        live--;
        return make_rsp(STS_REMOVED, s, 1);
      end
      if (it.action == ACT_INSERT) begin
        if (tbl_state[s] != SLOT_LIVE) begin
          tbl_key[s] = it.key;
          tbl_handle[s] = it.handle;
          tbl_state[s] = SLOT_LIVE;
          tbl_pref[s] = '0;
          if (mapped_range(it.handle)) begin
            map_ok[it.handle] = 1;
            map_slot[it.handle] = s;
          end
          live++;
          return make_rsp(STS_INSERTED, s, 1);
        end
      end else if (tbl_state[s] == SLOT_EMPTY) begin
        break;
      end
    end
    return make_rsp(it.action == ACT_INSERT ? STS_FULL : STS_NOT_FOUND, 0, 0);
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    live = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_state[i] = SLOT_EMPTY;
      tbl_key[i] = '0;
      tbl_handle[i] = '0;
      tbl_pref[i] = '0;
    end
    for (int i = 0; i < FD_LIMIT; i++) begin
      map_ok[i] = 0;
      map_slot[i] = 0;
    end
  end

  always @(posedge clk) begin
    req_item_t it;
    rsp_item_t want;
    if (!rst && req.valid && req.ready) begin
      it.action = action_t'(req.action);
      it.key = {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
      it.handle = req.handle;
      it.preferred_value = req.preferred_value;
      expected_rsp.push_back(registry_step(it));
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected response word", 1, 0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) report("status", rsp.status, want.status);
        if (rsp.slot !== want.slot) report("slot", rsp.slot, want.slot);
        if (rsp.peer_handle !== want.peer_handle)
          report("peer_handle", rsp.peer_handle, want.peer_handle);
        if (rsp.peer_preferred !== want.peer_preferred)
          report("peer_preferred", rsp.peer_preferred, want.peer_preferred);
        if (rsp.live_count !== want.live_count)
          report("live_count", rsp.live_count, want.live_count);
      end
    end
  end

endmodule

// ===== bench/tb_peer_key_hash_registry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer registry testbench
// Drives directed and random registry requests with random stalls on both
// channels, including a full-table fill and removal of the fill keys, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_peer_key_hash_registry_top;
  import pkhr_pkg::*;

  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int FD_LIMIT    = FD_LIMIT_DEF;
  localparam int RANDOM_WORDS = 260;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int POOL_SIZE = 48;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   calm;

  logic [255:0] key_pool[POOL_SIZE];
  logic [255:0] fill_keys[TABLE_SLOTS];

  pkhr_req_if req ();
  pkhr_rsp_if rsp ();

  peer_key_hash_registry_top #(.TABLE_SLOTS(TABLE_SLOTS), .FD_LIMIT(FD_LIMIT)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  pkhr_checker #(.TABLE_SLOTS(TABLE_SLOTS), .FD_LIMIT(FD_LIMIT)) chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Response stalls come in short bursts, with none once the run turns calm.
  initial begin
    int hold;
    rsp.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(0, 4);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic logic [255:0] rand_key();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  task automatic send_word(action_t act, logic [255:0] key, logic signed [15:0] h,
                           logic [7:0] pv);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    {req.key_word0, req.key_word1, req.key_word2, req.key_word3} <= key;
    req.handle <= h;
    req.preferred_value <= pv;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin
    logic [255:0] ka;
    logic [255:0] kb;
    logic [255:0] key;
    logic signed [15:0] h;
    action_t act;
    int pick;
    calm = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.action = ACT_LOOKUP;
    {req.key_word0, req.key_word1, req.key_word2, req.key_word3} = '0;
    req.handle = '0;
    req.preferred_value = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    // Half the pool shares home slots in pairs, so probe chains form.
    for (int i = 0; i < POOL_SIZE / 2; i += 2) begin
      do key_pool[i + 1] = rand_key();
      while (chk.key_home(key_pool[i + 1]) != chk.key_home(key_pool[i]));
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    send_word(ACT_LOOKUP, '0, 16'sd0, 8'h00);
    send_word(ACT_INSERT, '1, 16'sd0, 8'h00);
    send_word(ACT_INSERT, '1, 16'sd5, 8'h00);
    send_word(ACT_SETPREF, '0, 16'sd5, 8'hff);
    send_word(ACT_SETPREF, '1, 16'sd0, 8'h11);
    send_word(ACT_LOOKUP, '1, 16'sd0, 8'h00);
    send_word(ACT_INSERT, '0, -16'sd1, 8'h00);
    send_word(ACT_INSERT, {64'h8000000000000001, 192'h0}, 16'sh7fff, 8'h00);
    send_word(ACT_SETPREF, '0, -16'sd1, 8'h22);
    send_word(ACT_SETPREF, '0, 16'sh7fff, 8'h33);
    send_word(ACT_SETPREF, '0, 16'sd1023, 8'h44);
    send_word(ACT_REMOVE, '1, 16'sd0, 8'h00);
    send_word(ACT_REMOVE, '1, 16'sd0, 8'h00);
    send_word(ACT_LOOKUP, '1, 16'sd0, 8'h00);
    send_word(ACT_SETPREF, '0, 16'sd5, 8'h55);
    send_word(ACT_INSERT, '1, 16'sd1023, 8'h00);
    // A live key past a tombstone is missed and gets a second copy.
    ka = key_pool[0];
    kb = key_pool[1];
    send_word(ACT_INSERT, ka, 16'sd10, 8'h00);
    send_word(ACT_INSERT, kb, 16'sd11, 8'h00);
    send_word(ACT_REMOVE, ka, 16'sd0, 8'h00);
    send_word(ACT_INSERT, kb, 16'sd12, 8'h00);
    send_word(ACT_LOOKUP, kb, 16'sd0, 8'h00);
    send_word(ACT_SETPREF, '0, 16'sd11, 8'h5a);
    send_word(ACT_REMOVE, kb, 16'sd0, 8'h00);
    send_word(ACT_LOOKUP, kb, 16'sd0, 8'h00);

    // Fill the table to the brim, hit the full case, then remove the fill keys again.
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      fill_keys[i] = rand_key();
      send_word(ACT_INSERT, fill_keys[i], 16'($urandom_range(0, FD_LIMIT - 1)), 8'h00);
    end
    send_word(ACT_INSERT, rand_key(), 16'sd3, 8'h00);
    send_word(ACT_LOOKUP, rand_key(), 16'sd3, 8'h00);
    send_word(ACT_SETPREF, '0, 16'sd3, 8'h77);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      send_word(ACT_REMOVE, fill_keys[i], 16'sd0, 8'h00);
    end
    send_word(ACT_LOOKUP, fill_keys[0], 16'sd0, 8'h00);

    // Random part over a small key pool, so that hits and chains are common.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n > RANDOM_WORDS * 17 / 20) calm = 1;
      pick = $urandom_range(0, 99);
      if (pick < 30) act = ACT_LOOKUP;
      else if (pick < 62) act = ACT_INSERT;
      else if (pick < 85) act = ACT_REMOVE;
      else act = ACT_SETPREF;
      key = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 70) h = 16'($urandom_range(0, 63));
      else if (pick < 78) h = -16'sd1;
      else if (pick < 90) h = 16'($urandom_range(0, FD_LIMIT - 1));
      else h = 16'($urandom_range(0, 32767));
      send_word(act, key, h, 8'($urandom()));
    end
    @(negedge clk);
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
